[hdl/msa_pkg.sv]
// Shared types and constants for the multi-channel sound alarm.
// No dependencies; the top level and msa_channel import this package.
package msa_pkg;

  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W = 3;
  localparam int MAX_CHANNELS = 4;
  localparam int WINDOW_DEFAULT = 20;
  localparam int CHANNELS_DEFAULT = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_QUIET = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_BLUE = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_YELLOW = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_RED = 3'd4;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Per-beat control handed from the top level to each channel.
  typedef struct packed {
    logic commit;     // the staged beat moves to the result register
    logic old_valid;  // the ring slot being replaced has been written before
  } ring_ctl_t;

endpackage

[hdl/multi_channel_sound_alarm.sv]
// Top level of the multi-channel sound alarm: staging register, arm and
// warning-level control, result register. Depends on msa_pkg and msa_channel.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | arm_button, sample_0..sample_3
//   result  | out_valid/ out_ready | is_armed, alarm_level, detected, lamps,
//           |                      | mean_0..mean_3
//   config  | cfg_wr_en            | cfg_wr_data (detect threshold)
//
// One beat per cycle sustained while out_ready keeps the result flowing.
// A beat sits in the staging register while its ring RAM read returns, then
// the totals, means and alarm state update into the result register. A
// stalled result holds the staging beat; input still takes a beat whenever
// the staging slot empties in that cycle.
// Reset clears rings (through a fill flag), totals and arm flag, and sets the level to quiet.
module multi_channel_sound_alarm import msa_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT,
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               arm_button,
  input  logic [SAMPLE_W-1:0] sample_0,
  input  logic [SAMPLE_W-1:0] sample_1,
  input  logic [SAMPLE_W-1:0] sample_2,
  input  logic [SAMPLE_W-1:0] sample_3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_armed,
  output logic [LEVEL_W-1:0] alarm_level,
  output logic               detected,
  output logic               lamp_blue,
  output logic               lamp_yellow,
  output logic               lamp_red,
  output logic [SAMPLE_W-1:0] mean_0,
  output logic [SAMPLE_W-1:0] mean_1,
  output logic [SAMPLE_W-1:0] mean_2,
  output logic [SAMPLE_W-1:0] mean_3,
  input  logic               cfg_wr_en,
  input  logic [SAMPLE_W-1:0] cfg_wr_data
);

  localparam int POS_W = $clog2(WINDOW);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  sample_t          threshold;
  logic [POS_W-1:0] pos;
  logic             ring_full;
  logic             in_fire;
  logic             commit;

  logic             s1_valid;
  logic             s1_button;
  logic             s1_old_valid;
  logic [POS_W-1:0] s1_pos;
  sample_t          s1_sample [CHANNELS];
  sample_t          in_sample [MAX_CHANNELS];

  logic [POS_W-1:0] rd_pos;
  ring_ctl_t        ring_ctl;
  sample_t          mean_next [MAX_CHANNELS];
  sample_t          mean_q [MAX_CHANNELS];

  logic               armed;
  logic [LEVEL_W-1:0] level;
  logic               armed_pre;
  logic [LEVEL_W-1:0] level_pre;
  logic               hit;
  logic               det_next;
  logic               armed_next;
  logic [LEVEL_W-1:0] level_next;

  assign in_sample[0] = sample_0;
  assign in_sample[1] = sample_1;
  assign in_sample[2] = sample_2;
  assign in_sample[3] = sample_3;

  assign commit = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || commit;
  assign in_fire = in_valid && in_ready;

  // The RAM read address follows the beat being staged, so the read data
  // lines up with the staging register in the next cycle and holds on a stall.
  assign rd_pos = in_fire ? pos : s1_pos;
  assign ring_ctl.commit = commit;
  assign ring_ctl.old_valid = s1_old_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // Ring position and fill flag advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ring_full <= 1'b0;
    end else if (in_fire) begin
      pos <= (pos == POS_LAST) ? '0 : pos + 1'b1;
      if (pos == POS_LAST) begin
        ring_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_button <= arm_button;
      s1_old_valid <= ring_full;
      s1_pos <= pos;
    end
  end

  genvar c;
  generate
    for (c = 0; c < MAX_CHANNELS; c++) begin : g_ch
      if (c < CHANNELS) begin : g_used
        always_ff @(posedge clk) begin
          if (in_fire) begin
            s1_sample[c] <= in_sample[c];
          end
        end

        msa_channel #(
          .WINDOW(WINDOW)
        ) u_channel (
          .clk   (clk),
          .rst   (rst),
          .ctl   (ring_ctl),
          .rd_pos(rd_pos),
          .wr_pos(s1_pos),
          .sample(s1_sample[c]),
          .mean  (mean_next[c])
        );
      end else begin : g_unused
        assign mean_next[c] = '0;
      end
    end
  endgenerate

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (mean_next[i] >= threshold) begin
        hit = 1'b1;
      end
    end

    // A press rearms and brings a maxed-out level back to quiet first.
    armed_pre = armed || s1_button;
    level_pre = (s1_button && level >= LEVEL_RED) ? LEVEL_QUIET : level;

    det_next = hit && armed_pre;
    armed_next = det_next ? 1'b0 : armed_pre;
    level_next = (det_next && level_pre < LEVEL_RED) ? level_pre + 1'b1 : level_pre;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      level <= LEVEL_QUIET;
    end else if (commit) begin
      armed <= armed_next;
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      is_armed <= armed_next;
      alarm_level <= level_next;
      detected <= det_next;
      lamp_blue <= (level_next == LEVEL_BLUE);
      lamp_yellow <= (level_next == LEVEL_YELLOW);
      lamp_red <= (level_next == LEVEL_RED);
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        mean_q[i] <= mean_next[i];
      end
    end
  end

  assign mean_0 = mean_q[0];
  assign mean_1 = mean_q[1];
  assign mean_2 = mean_q[2];
  assign mean_3 = mean_q[3];

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level >= LEVEL_QUIET && level <= LEVEL_RED)
    else $error("warning level left its range");

  a_detect_disarms: assert property (@(posedge clk) disable iff (rst)
    out_valid && detected |-> !is_armed)
    else $error("a detection beat left the detector armed");

  a_one_lamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({lamp_blue, lamp_yellow, lamp_red}))
    else $error("more than one lamp lit");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !commit |=> s1_valid && $stable(s1_pos))
    else $error("staged beat lost during a result stall");

endmodule

[hdl/msa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the per-channel sample rings.
module msa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 20,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/msa_channel.sv]
// One sensor channel: sample ring, running total and truncated mean.
// Depends on msa_pkg and msa_ram.
module msa_channel import msa_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT,
  parameter int POS_W = $clog2(WINDOW)
) (
  input  logic             clk,
  input  logic             rst,
  input  ring_ctl_t        ctl,
  input  logic [POS_W-1:0] rd_pos,
  input  logic [POS_W-1:0] wr_pos,
  input  sample_t          sample,
  output sample_t          mean
);

  localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
  // Division by the window length as a multiply by a rounded-up reciprocal;
  // this shift makes the quotient exact over the whole range of the total.
  localparam int SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + WINDOW - 1) / WINDOW);

  logic [SUM_W-1:0]  total;
  logic [SUM_W-1:0]  total_next;
  logic [SUM_W-1:0]  old_sample;
  logic [PROD_W-1:0] product;
  sample_t           ram_rdata;

  msa_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ctl.commit),
    .waddr(wr_pos),
    .wdata(sample),
    .raddr(rd_pos),
    .rdata(ram_rdata)
  );

  // Slots not yet written since reset count as zero.
  assign old_sample = ctl.old_valid ? SUM_W'(ram_rdata) : '0;
  assign total_next = total - old_sample + SUM_W'(sample);
  assign product = PROD_W'(total_next) * PROD_W'(RECIP);
  assign mean = product[SHIFT +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctl.commit) begin
      total <= total_next;
    end
  end

endmodule
